// ===== sv/cor_pkg.sv =====
`default_nettype none
package cor_pkg;

  // Default field widths
  localparam int CoordBitsDef  = 12;
  localparam int RadiusBitsDef = 10;

  // Depth of the step queue between front and back (power of two)
  localparam int QueueDepth = 2;

  // Command codes carried in s_axis_tuser
  localparam logic CmdStart   = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  // Last mirrored position of a step
  localparam logic [2:0] OctantLast = 3'd7;

  // Signed width of an output coordinate: wide enough for centre +/- radius
  function automatic int point_bits(input int coord_bits, input int radius_bits);
    point_bits = ((coord_bits > radius_bits) ? coord_bits : radius_bits) + 2;
  endfunction

  // Width of one queued step: cx, cy, inner, outer, last
  function automatic int step_bits(input int coord_bits, input int radius_bits);
    step_bits = 2 * coord_bits + 2 * radius_bits + 4;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cor_fifo.sv =====
`default_nettype none
module cor_fifo
  import cor_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output logic                  empty_o
);

  localparam int Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [Aw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [Aw:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == (Aw+1)'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cor_front.sv =====
`default_nettype none
module cor_front
  import cor_pkg::*;
#(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef,
  parameter int STEP_BITS   = step_bits(CoordBitsDef, RadiusBitsDef)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire logic                   command_i,
  input  wire logic [COORD_BITS-1:0]  center_x_i,
  input  wire logic [COORD_BITS-1:0]  center_y_i,
  input  wire logic [RADIUS_BITS-1:0] radius_i,
  output logic                        step_push_o,
  output logic [STEP_BITS-1:0]        step_data_o
);

  localparam int Iw = RADIUS_BITS + 1;  // inner offset
  localparam int Ow = RADIUS_BITS + 2;  // outer offset, signed
  localparam int Dw = RADIUS_BITS + 3;  // decision, signed
  localparam int Aw = RADIUS_BITS + 4;  // working width of the step arithmetic

  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] r_q;
  logic [Iw-1:0]          i_q, i_d;
  logic signed [Ow-1:0]   o_q, o_d;
  logic signed [Dw-1:0]   d_q, d_d;
  logic                   busy_q;

  logic signed [Aw-1:0] ai, ao, ad, ar, ai_n, ao_n, ad_n;
  logic                 is_start, is_step, last_step;

  assign is_start = cmd_valid_i && (command_i == CmdStart);
  assign is_step  = cmd_valid_i && (command_i == CmdAdvance) && busy_q;

  // One step of the decision update, three cases
  always_comb begin
    ai = Aw'(i_q);
    ao = Aw'(o_q);
    ad = Aw'(d_q);
    ar = Aw'(r_q);
    if (ad >= (ai + ai)) begin
      ad_n = ad - (ai + ai) - Aw'(1);
      ai_n = ai + Aw'(1);
      ao_n = ao;
    end else if (ad < ((ar - ao) + (ar - ao))) begin
      ad_n = ad + (ao + ao) - Aw'(1);
      ai_n = ai;
      ao_n = ao - Aw'(1);
    end else begin
      ad_n = ad + ((ao - ai - Aw'(1)) + (ao - ai - Aw'(1)));
      ai_n = ai + Aw'(1);
      ao_n = ao - Aw'(1);
    end
    last_step = (ao_n < ai_n);
    i_d = i_q;
    o_d = o_q;
    d_d = d_q;
    if (is_start) begin
      i_d = '0;
      o_d = Ow'(radius_i);
      d_d = Dw'(radius_i) - Dw'(1);
    end else if (is_step) begin
      i_d = ai_n[Iw-1:0];
      o_d = ao_n[Ow-1:0];
      d_d = ad_n[Dw-1:0];
    end
  end

  // Queued step: the offsets before the update, plus the final flag
  assign step_push_o = is_step;
  assign step_data_o = {last_step, o_q, i_q, cy_q, cx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      r_q    <= '0;
      i_q    <= '0;
      o_q    <= '0;
      d_q    <= '0;
      busy_q <= 1'b0;
    end else begin
      i_q <= i_d;
      o_q <= o_d;
      d_q <= d_d;
      if (is_start) begin
        cx_q   <= center_x_i;
        cy_q   <= center_y_i;
        r_q    <= radius_i;
        busy_q <= 1'b1;
      end else if (is_step && last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/cor_back.sv =====
`default_nettype none
module cor_back
  import cor_pkg::*;
#(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef,
  parameter int STEP_BITS   = step_bits(CoordBitsDef, RadiusBitsDef),
  parameter int POINT_BITS  = point_bits(CoordBitsDef, RadiusBitsDef)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_empty_i,
  input  wire logic [STEP_BITS-1:0]  step_data_i,
  output logic                       step_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [POINT_BITS-1:0] point_x_o,
  output logic signed [POINT_BITS-1:0] point_y_o,
  output logic [2:0]                 octant_o,
  output logic                       last_o
);

  localparam int Iw = RADIUS_BITS + 1;
  localparam int Ow = RADIUS_BITS + 2;

  logic [COORD_BITS-1:0] cx, cy;
  logic [Iw-1:0]         si;
  logic signed [Ow-1:0]  so;
  logic                  slast;

  logic [2:0] k_q;
  logic       out_v_q;
  logic       load;

  logic signed [POINT_BITS-1:0] pcx, pcy, pi, po, ax, ay, px, py;

  assign {slast, so, si, cy, cx} = step_data_i;

  // Mirror selection: bit0 swaps offsets, bit1 negates x, bit2 negates y
  always_comb begin
    pcx = POINT_BITS'(cx);
    pcy = POINT_BITS'(cy);
    pi  = POINT_BITS'(si);
    po  = POINT_BITS'(so);
    ax  = k_q[0] ? po : pi;
    ay  = k_q[0] ? pi : po;
    px  = k_q[1] ? (pcx - ax) : (pcx + ax);
    py  = k_q[2] ? (pcy - ay) : (pcy + ay);
  end

  // Output register loads when empty or being drained
  assign load        = !step_empty_i && (!out_v_q || out_ready_i);
  assign step_pop_o  = load && (k_q == OctantLast);
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        k_q     <= k_q + 1'b1;
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      point_x_o <= px;
      point_y_o <= py;
      octant_o  <= k_q;
      last_o    <= slast && (k_q == OctantLast);
    end
  end

endmodule
`default_nettype wire

// ===== sv/circle_outline_rasterizer_top.sv =====
`default_nettype none
// Circle outline rasterizer (Andres' digital circle). A transaction with
// tuser = 0 starts a circle from the centre and radius in tdata and gives no
// output; each transaction with tuser = 1 then gives the eight mirrored
// outline points of one step, one point per cycle while the sink is ready,
// octant 0..7 in tuser and tlast on the eighth point of the final step. An
// advance with no circle in progress gives nothing. The front section does
// one decision step per cycle while the queue has room and queues it; the
// back section emits the points through a registered output. Up to two steps
// are buffered, so advances are accepted on consecutive cycles until the
// queue is full. A start does not disturb points already queued.
module circle_outline_rasterizer_top
  import cor_pkg::*;
#(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef,
  localparam int PointBits  = point_bits(COORD_BITS, RADIUS_BITS),
  localparam int InBits     = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  localparam int OutBits    = ((2 * PointBits + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // center_x, center_y, radius (low bits up), zero padded
  input  wire logic [InBits-1:0]  s_axis_tdata,
  // command
  input  wire logic [0:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // point_x, point_y (low bits up), zero padded
  output logic [OutBits-1:0]      m_axis_tdata,
  // octant
  output logic [2:0]              m_axis_tuser,
  output logic                    m_axis_tlast
);

  localparam int StepBits = step_bits(COORD_BITS, RADIUS_BITS);

  logic                 cmd_valid, q_full, q_empty, q_push, q_pop;
  logic [StepBits-1:0]  q_wdata, q_rdata;
  logic signed [PointBits-1:0] point_x, point_y;

  assign s_axis_tready = !q_full;
  assign cmd_valid     = s_axis_tvalid && s_axis_tready;

  cor_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .STEP_BITS  (StepBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .command_i  (s_axis_tuser[0]),
    .center_x_i (s_axis_tdata[COORD_BITS-1:0]),
    .center_y_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius_i   (s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .step_push_o(q_push),
    .step_data_o(q_wdata)
  );

  cor_fifo #(
    .WIDTH(StepBits),
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (q_rdata),
    .empty_o    (q_empty)
  );

  cor_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .STEP_BITS  (StepBits),
    .POINT_BITS (PointBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_empty_i(q_empty),
    .step_data_i (q_rdata),
    .step_pop_o  (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .octant_o    (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OutBits'({point_y, point_x});

endmodule
`default_nettype wire

// ===== tb/circle_outline_rasterizer_top_test.sv =====
`default_nettype none
module circle_outline_rasterizer_top_test;
  import cor_pkg::*;

  localparam int CoordW = CoordBitsDef;
  localparam int RadW   = RadiusBitsDef;
  localparam int PtW    = point_bits(CoordBitsDef, RadiusBitsDef);
  localparam int InW    = ((2 * CoordW + RadW + 7) / 8) * 8;
  localparam int OutW   = ((2 * PtW + 7) / 8) * 8;
  localparam logic [CoordW-1:0] CoordMax = '1;
  localparam logic [RadW-1:0]   RadMax   = '1;

  typedef struct packed {
    logic [PtW-1:0] px;
    logic [PtW-1:0] py;
    logic [2:0]     octant;
    logic           last;
  } outline_point_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [InW-1:0]    s_axis_tdata;   // center_x, center_y, radius
  logic [0:0]        s_axis_tuser;   // command
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OutW-1:0]   m_axis_tdata;   // point_x, point_y
  logic [2:0]        m_axis_tuser;   // octant
  logic              m_axis_tlast;

  circle_outline_rasterizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predicted circle state
  int circ_cx, circ_cy, circ_r;
  int off_in, off_out, dvar;
  bit circle_active;

  outline_point_t expected_points[$];

  int mismatches;
  int points_checked;
  int circles_started;
  int circles_done;
  int useful_items;
  int gap_pct;
  int stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Expected points of one transaction; updates the predicted circle state
  task automatic rasterize_step(input logic cmd, input logic [CoordW-1:0] cx,
                                input logic [CoordW-1:0] cy, input logic [RadW-1:0] r);
    int i, o, a, b, px, py;
    bit done;
    outline_point_t pt;
    if (cmd == CmdStart) begin
      circ_cx = cx;
      circ_cy = cy;
      circ_r = r;
      off_in = 0;
      off_out = r;
      dvar = int'(r) - 1;
      circle_active = 1'b1;
      circles_started++;
      return;
    end
    if (!circle_active) return;
    i = off_in;
    o = off_out;
    // three-way decision update
    if (dvar >= 2 * i) begin
      dvar -= 2 * i + 1;
      off_in = i + 1;
    end else if (dvar < 2 * (circ_r - o)) begin
      dvar += 2 * o - 1;
      off_out = o - 1;
    end else begin
      dvar += 2 * (o - i - 1);
      off_out = o - 1;
      off_in = i + 1;
    end
    done = (off_out < off_in);
    if (done) begin
      circle_active = 1'b0;
      circles_done++;
    end
    // octant bit 0 swaps offsets, bit 1 mirrors x, bit 2 mirrors y
    for (int k = 0; k < 8; k++) begin
      a = k[0] ? o : i;
      b = k[0] ? i : o;
      px = circ_cx + (k[1] ? -a : a);
      py = circ_cy + (k[2] ? -b : b);
      pt.px = PtW'(px);
      pt.py = PtW'(py);
      pt.octant = 3'(k);
      pt.last = done && (k == 7);
      expected_points.push_back(pt);
    end
  endtask

  // Send one transaction, with an optional idle burst before it
  task automatic send_item(input logic cmd, input logic [CoordW-1:0] cx,
                           input logic [CoordW-1:0] cy, input logic [RadW-1:0] r);
    @(negedge clk_i);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tdata <= {{(InW - 2 * CoordW - RadW){1'b0}}, r, cy, cx};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CmdStart || circle_active) useful_items++;
    rasterize_step(cmd, cx, cy, r);
  endtask

  task automatic advance();
    send_item(CmdAdvance, CoordW'($urandom), CoordW'($urandom), RadW'($urandom));
  endtask

  // Output checker
  always @(posedge clk_i) begin
    outline_point_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[PtW-1:0];
      got.py = m_axis_tdata[2*PtW-1:PtW];
      got.octant = m_axis_tuser;
      got.last = m_axis_tlast;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%0d y=%0d octant=%0d last=%0b",
                   $signed(got.px), $signed(got.py), got.octant, got.last);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (got.px !== want.px || got.py !== want.py || got.octant !== want.octant ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("point mismatch: expected x=%0d y=%0d octant=%0d last=%0b",
                     $signed(want.px), $signed(want.py), want.octant, want.last);
            $display("                got      x=%0d y=%0d octant=%0d last=%0b",
                     $signed(got.px), $signed(got.py), got.octant, got.last);
          end
        end
      end
    end
  end

  // Sink backpressure in random bursts
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Idle advances, zero radius, small circle near the far corner
  task automatic test_idle_and_zero_radius();
    gap_pct = 20;
    stall_pct = 20;
    advance();
    send_item(CmdStart, '0, '0, '0);
    advance();
    advance();
    send_item(CmdStart, CoordMax, CoordMax, RadW'(1));
    while (circle_active) advance();
  endtask

  // Largest radius at both corners, restarts while busy
  task automatic test_extremes_and_restart();
    send_item(CmdStart, '0, '0, RadMax);
    repeat (3) advance();
    send_item(CmdStart, CoordMax, CoordMax, RadMax);
    repeat (3) advance();
    send_item(CmdStart, '0, CoordMax, RadW'(2));
    while (circle_active) advance();
    advance();
  endtask

  // Mostly whole circles with random content, some aborted, some noise
  task automatic test_random_circles(input int target, input bit idling);
    int pick, limit, steps;
    logic [CoordW-1:0] cx, cy;
    logic [RadW-1:0] r;
    while (useful_items < target) begin
      if (idling) begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        advance();
      end else begin
        case ($urandom_range(0, 3))
          0: cx = '0;
          1: cx = CoordMax;
          default: cx = CoordW'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: cy = '0;
          1: cy = CoordMax;
          default: cy = CoordW'($urandom);
        endcase
        limit = 1 << 30;
        if (pick < 75) begin
          r = RadW'($urandom_range(0, 12));
        end else if (pick < 85) begin
          r = RadW'($urandom_range(13, 30));
        end else begin
          r = RadW'($urandom);
          limit = $urandom_range(1, 5);
        end
        if ($urandom_range(0, 9) == 0) limit = $urandom_range(0, 3);
        send_item(CmdStart, cx, cy, r);
        steps = 0;
        while (circle_active && steps < limit) begin
          advance();
          steps++;
        end
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    int waited;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CmdStart;
    mismatches = 0;
    points_checked = 0;
    circles_started = 0;
    circles_done = 0;
    useful_items = 0;
    gap_pct = 0;
    stall_pct = 0;
    circle_active = 1'b0;
    circ_cx = 0;
    circ_cy = 0;
    circ_r = 0;
    off_in = 0;
    off_out = 0;
    dvar = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_zero_radius();
    test_extremes_and_restart();
    test_random_circles(400, 1'b1);
    test_random_circles(460, 1'b0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      mismatches += expected_points.size();
      $display("%0d expected points never arrived", expected_points.size());
    end

    $display("Covered %0d circle starts (%0d drawn to the end) with idle advances.",
             circles_started, circles_done);
    $display("Checked %0d outline points, %0d mismatching or missing.",
             points_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
